// File: rtl/tlpt_pkg.sv
`timescale 1ns / 1ps

package tlpt_pkg;

  // fixed x86 two-level split of a 32-bit virtual address
  localparam int DIR_IDX_W = 10;
  localparam int OFFSET_W  = 12;
  localparam int FRAME_W   = 20;
  localparam int FLAGS_W   = 12;
  localparam int CMD_W     = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_MAP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNMAP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_XLATE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic clear;   // clearing sweep step
    logic accept;  // input word taken, issue directory read
    logic dir_go;  // directory entry valid, issue table read
    logic tbl_go;  // table entry valid, write back and load result
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep at its last entry
    logic out_free;    // result register can take a word
  } ctl_sts_t;

endpackage

// File: rtl/tlpt_ram.sv
`timescale 1ns / 1ps

module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/tlpt_ctrl.sv
`timescale 1ns / 1ps

module tlpt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tlpt_pkg::ctl_sts_t sts_i,
  output tlpt_pkg::ctl_cmd_t cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DIR   = 2'd2;
  localparam logic [1:0] ST_TBL   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DIR;
        end
      end
      ST_DIR: begin
        cmd_o.dir_go = 1'b1;
        state_d      = ST_TBL;
      end
      ST_TBL: begin
        // hold until the result register is free
        if (sts_i.out_free) begin
          cmd_o.tbl_go = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/tlpt_datapath.sv
`timescale 1ns / 1ps

module tlpt_datapath #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlpt_pkg::ctl_cmd_t cmd_i,
  output tlpt_pkg::ctl_sts_t sts_o,
  input  logic [1:0]         in_cmd_i,
  input  logic [31:0]        in_va_i,
  input  logic [31:0]        in_pa_i,
  input  logic [11:0]        in_flags_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [31:0]        out_phys_o,
  output logic               out_not_mapped_o,
  output logic               out_was_mapped_o,
  output logic               out_status_o
);

  localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W   = tlpt_pkg::DIR_IDX_W;
  localparam int ENTRIES = 1 << IDX_W;
  localparam int TDEPTH  = TABLE_SLOTS * ENTRIES;
  localparam int TA_W    = $clog2(TDEPTH);
  localparam int DIR_LSB = tlpt_pkg::OFFSET_W + IDX_W;
  localparam int OFF_W   = tlpt_pkg::OFFSET_W;

  // latched command
  logic [tlpt_pkg::CMD_W-1:0]   cmd_q;
  logic [31:0]                  va_q;
  logic [tlpt_pkg::FRAME_W-1:0] pa_q;
  logic [tlpt_pkg::FLAGS_W-1:0] fl_q;

  logic [TA_W-1:0]  clr_q;
  logic [CNT_W-1:0] next_slot_q;
  logic             hit_q, hit_d;
  logic             fail_q, fail_d;
  logic [TA_W-1:0]  taddr_q;

  logic             out_valid_q;
  logic [31:0]      phys_q, phys_d;
  logic             nm_q, nm_d;
  logic             wm_q, wm_d;
  logic             st_q, st_d;

  // directory port signals
  logic              dir_we;
  logic [IDX_W-1:0]  dir_waddr;
  logic [SLOT_W:0]   dir_wdata;
  logic [SLOT_W:0]   dir_rdata;
  logic              dir_pres;
  logic [SLOT_W-1:0] slot_sel;
  logic              pool_full;
  logic              alloc;

  // table port signals
  logic                    tbl_we;
  logic [TA_W-1:0]         tbl_waddr;
  logic [31:0]             tbl_wdata;
  logic                    tbl_re;
  logic [SLOT_W+IDX_W-1:0] taddr_full;
  logic [TA_W-1:0]         taddr;
  logic [31:0]             tbl_rdata;

  assign sts_o.clear_last = (clr_q == TA_W'(TDEPTH - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign dir_pres  = dir_rdata[SLOT_W];
  assign pool_full = (next_slot_q == CNT_W'(TABLE_SLOTS));

  // directory stage: find or create the table
  always_comb begin
    hit_d    = hit_q;
    fail_d   = fail_q;
    slot_sel = dir_rdata[SLOT_W-1:0];
    alloc    = 1'b0;
    if (cmd_i.dir_go) begin
      hit_d  = 1'b0;
      fail_d = 1'b0;
      case (cmd_q)
        tlpt_pkg::CMD_MAP: begin
          if (dir_pres) begin
            hit_d = 1'b1;
          end else if (pool_full) begin
            fail_d = 1'b1;
          end else begin
            alloc    = 1'b1;
            hit_d    = 1'b1;
            slot_sel = next_slot_q[SLOT_W-1:0];
          end
        end
        tlpt_pkg::CMD_UNMAP, tlpt_pkg::CMD_XLATE: begin
          hit_d = dir_pres;
        end
        default: begin
          hit_d = 1'b0;
        end
      endcase
    end
  end

  assign dir_we     = cmd_i.clear || alloc;
  assign dir_waddr  = cmd_i.clear ? clr_q[IDX_W-1:0] : va_q[DIR_LSB +: IDX_W];
  assign dir_wdata  = cmd_i.clear ? '0 : {1'b1, next_slot_q[SLOT_W-1:0]};

  assign taddr_full = {slot_sel, va_q[OFF_W +: IDX_W]};
  assign taddr      = taddr_full[TA_W-1:0];
  assign tbl_re     = cmd_i.dir_go && hit_d;

  // table stage: write back and form the result
  always_comb begin
    tbl_we    = cmd_i.clear;
    tbl_waddr = cmd_i.clear ? clr_q : taddr_q;
    tbl_wdata = '0;
    phys_d    = '0;
    nm_d      = 1'b0;
    wm_d      = 1'b0;
    st_d      = 1'b0;
    if (cmd_i.tbl_go) begin
      case (cmd_q)
        tlpt_pkg::CMD_MAP: begin
          st_d = fail_q;
          if (hit_q) begin
            tbl_we    = 1'b1;
            tbl_wdata = {pa_q, fl_q[tlpt_pkg::FLAGS_W-1:1], 1'b1};
            wm_d      = tbl_rdata[0];
          end
        end
        tlpt_pkg::CMD_UNMAP: begin
          if (hit_q && tbl_rdata[0]) begin
            tbl_we = 1'b1;
          end
        end
        tlpt_pkg::CMD_XLATE: begin
          if (hit_q && tbl_rdata[0]) begin
            phys_d = {tbl_rdata[31:OFF_W], va_q[OFF_W-1:0]};
          end else begin
            nm_d = 1'b1;
          end
        end
        default: begin
          st_d = 1'b0;
        end
      endcase
    end
  end

  tlpt_ram #(
    .WIDTH (SLOT_W + 1),
    .DEPTH (ENTRIES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (in_va_i[DIR_LSB +: IDX_W]),
    .rdata_o (dir_rdata)
  );

  tlpt_ram #(
    .WIDTH (32),
    .DEPTH (TDEPTH)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (taddr),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      next_slot_q <= '0;
      hit_q       <= 1'b0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + TA_W'(1);
      end
      if (alloc) begin
        next_slot_q <= next_slot_q + CNT_W'(1);
      end
      hit_q  <= hit_d;
      fail_q <= fail_d;
      if (cmd_i.tbl_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= in_cmd_i;
      va_q  <= in_va_i;
      pa_q  <= in_pa_i[31:OFF_W];
      fl_q  <= in_flags_i;
    end
    if (cmd_i.dir_go) begin
      taddr_q <= taddr;
    end
    if (cmd_i.tbl_go) begin
      phys_q <= phys_d;
      nm_q   <= nm_d;
      wm_q   <= wm_d;
      st_q   <= st_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_phys_o       = phys_q;
  assign out_not_mapped_o = nm_q;
  assign out_was_mapped_o = wm_q;
  assign out_status_o     = st_q;

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_slot_q <= CNT_W'(TABLE_SLOTS))
    else $error("slot counter beyond pool size");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tbl_go |-> sts_o.out_free)
    else $error("result loaded over a word not yet taken");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && st_q |-> !nm_q && !wm_q && (phys_q == '0))
    else $error("failed map carries other result fields");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> !cmd_i.accept && !alloc && !cmd_i.tbl_go)
    else $error("store accessed during clearing sweep");

endmodule

// File: rtl/two_level_page_table_engine_core.sv
`timescale 1ns / 1ps

// two-level x86-style page table engine. each input word is a map, unmap or
// translate command and yields exactly one result word. a 1024-entry directory
// (virtual address bits 31..22) points at one of TABLE_SLOTS page tables of
// 1024 entries (bits 21..12). map creates a missing table by taking the next
// slot of the pool, writes frame, flags and present, and flags was_mapped when
// a live entry was overwritten; when the pool is empty it reports status 1 and
// writes nothing. unmap clears a present entry, translate returns frame plus
// page offset or raises not_mapped. after reset the block runs a clearing sweep
// over both stores with tready low. then a command goes from acceptance through
// the directory read, the dependent table read, and the table write with the
// result load, which waits until the result register is free; the steps follow
// the chain of accesses through the two single-port-pair memories. the next
// word is accepted while a finished result still waits in the output register.
module two_level_page_table_engine_core #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command word in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // virt_addr[31:0], phys_addr[63:32], map_flags[75:64], zero
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  // result word out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // phys_result[31:0]
  output logic [2:0]  m_axis_tuser    // not_mapped[0], was_mapped[1], status[2]
);

  tlpt_pkg::ctl_cmd_t ctl_cmd;
  tlpt_pkg::ctl_sts_t ctl_sts;

  // sequencer: clearing sweep, then accept / directory / table steps
  tlpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  // stores, slot pool and result register
  tlpt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctl_cmd),
    .sts_o            (ctl_sts),
    .in_cmd_i         (s_axis_tuser),
    .in_va_i          (s_axis_tdata[31:0]),
    .in_pa_i          (s_axis_tdata[63:32]),
    .in_flags_i       (s_axis_tdata[75:64]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_phys_o       (m_axis_tdata),
    .out_not_mapped_o (m_axis_tuser[0]),
    .out_was_mapped_o (m_axis_tuser[1]),
    .out_status_o     (m_axis_tuser[2])
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int TABLE_SLOTS = 16;
  localparam int LEVEL_ENTRIES = 1024;
  // code 3 is not a command, the block answers with an all-zero word
  localparam logic [tlpt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [tlpt_pkg::FLAGS_W-1:0] ENTRY_VALID_FLAG = 12'h001;
  localparam int HOT_DIRS = 20;
  localparam int HOT_TBLS = 12;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [tlpt_pkg::CMD_W-1:0]   cmd;
    logic [31:0]                  va;
    logic [31:0]                  pa;
    logic [tlpt_pkg::FLAGS_W-1:0] flags;
  } pt_cmd_t;

  typedef struct packed {
    logic [31:0] phys;
    logic        not_mapped;
    logic        was_mapped;
    logic        status;
  } walk_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // virt_addr[31:0], phys_addr[63:32], map_flags[75:64], zero
  logic [1:0]  s_axis_tuser = '0;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // phys_result[31:0]
  logic [2:0]  m_axis_tuser;        // not_mapped[0], was_mapped[1], status[2]

  two_level_page_table_engine_core #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the page tables
  bit          dir_valid [LEVEL_ENTRIES];
  int unsigned dir_slot  [LEVEL_ENTRIES];
  bit   [31:0] pte_mem   [TABLE_SLOTS*LEVEL_ENTRIES];
  int unsigned slots_used = 0;

  walk_result_t expected_results[$];
  logic [9:0] hot_dirs [HOT_DIRS];
  logic [9:0] hot_tbls [HOT_TBLS];

  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_output = 1'b0;

  int error_count = 0;
  int words_sent = 0;
  int n_map = 0, n_unmap = 0, n_xlate = 0, n_unused = 0;
  int n_pool_full = 0, n_overwrite = 0, n_hit = 0;

  task automatic report_mismatch(string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // applies one command to the shadow tables and returns the word it yields
  function automatic walk_result_t walk_predict(pt_cmd_t c);
    walk_result_t r;
    int unsigned  di, ti, idx;
    r  = '0;
    di = c.va[31:22];
    ti = c.va[21:12];
    case (c.cmd)
      tlpt_pkg::CMD_MAP: begin
        n_map++;
        if (!dir_valid[di] && slots_used >= TABLE_SLOTS) begin
          r.status = 1'b1;
          n_pool_full++;
        end else begin
          if (!dir_valid[di]) begin
            dir_valid[di] = 1'b1;
            dir_slot[di]  = slots_used;
            slots_used++;
          end
          idx = dir_slot[di] * LEVEL_ENTRIES + ti;
          r.was_mapped = pte_mem[idx][0];
          if (r.was_mapped) n_overwrite++;
          pte_mem[idx] = {c.pa[31:12], c.flags | ENTRY_VALID_FLAG};
        end
      end
      tlpt_pkg::CMD_UNMAP: begin
        n_unmap++;
        if (dir_valid[di]) begin
          idx = dir_slot[di] * LEVEL_ENTRIES + ti;
          if (pte_mem[idx][0]) pte_mem[idx] = '0;
        end
      end
      tlpt_pkg::CMD_XLATE: begin
        n_xlate++;
        idx = dir_slot[di] * LEVEL_ENTRIES + ti;
        if (dir_valid[di] && pte_mem[idx][0]) begin
          r.phys = {pte_mem[idx][31:12], c.va[11:0]};
          n_hit++;
        end else begin
          r.not_mapped = 1'b1;
        end
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // offers one command word; the caller is at the edge of the previous handshake
  task automatic send_cmd(logic [1:0] cmd, logic [31:0] va, logic [31:0] pa,
                          logic [11:0] flags);
    int      gap;
    pt_cmd_t c;
    gap = tx_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, flags, pa, va};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    c = '{cmd: cmd, va: va, pa: pa, flags: flags};
    expected_results.push_back(walk_predict(c));
    words_sent++;
  endtask

  // sender goes quiet until every outstanding word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // mostly addresses inside the hot directories and tables so walks often hit real entries
  function automatic logic [31:0] pick_va(logic [1:0] cmd);
    logic [9:0] di, ti;
    if ($urandom_range(0, 99) < 12 &&
        !(cmd == tlpt_pkg::CMD_MAP && slots_used < TABLE_SLOTS))
      return $urandom;
    di = hot_dirs[$urandom_range(0, HOT_DIRS - 1)];
    ti = hot_tbls[$urandom_range(0, HOT_TBLS - 1)];
    return {di, ti, 12'($urandom)};
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return tlpt_pkg::CMD_MAP;
    if (r < 55) return tlpt_pkg::CMD_UNMAP;
    if (r < 95) return tlpt_pkg::CMD_XLATE;
    return CMD_UNUSED;
  endfunction

  function automatic logic [9:0] free_dir();
    int start;
    start = $urandom_range(0, LEVEL_ENTRIES - 1);
    for (int k = 0; k < LEVEL_ENTRIES; k++) begin
      if (!dir_valid[(start + k) % LEVEL_ENTRIES]) return 10'((start + k) % LEVEL_ENTRIES);
    end
    return '0;
  endfunction

  task automatic test_directed_walks();
    send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0000, 32'h0, 12'h0);           // no table yet
    send_cmd(tlpt_pkg::CMD_UNMAP, 32'h1234_5678, 32'h0, 12'h0);           // no table, no change
    send_cmd(tlpt_pkg::CMD_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFE); // present forced on
    send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0FFF, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_MAP,   32'h0000_0000, 32'h0000_0000, 12'h000); // overwrite live entry
    send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_0000, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_XLATE, 32'h0000_1000, 32'h0, 12'h0);   // table there, entry absent
    send_cmd(tlpt_pkg::CMD_UNMAP, 32'h0000_1000, 32'h0, 12'h0);   // unmap of absent entry
    send_cmd(tlpt_pkg::CMD_MAP,   32'hFFFF_FFFF, 32'h1234_5ABC, 12'hFFF);
    send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_UNMAP, 32'hFFFF_F000, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_MAP,   32'hFFFF_F000, 32'hA5A5_A5A5, 12'h5A5); // remap after unmap
    send_cmd(tlpt_pkg::CMD_XLATE, 32'hFFFF_F123, 32'h0, 12'h0);
    send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_cmd(CMD_UNUSED, 32'h0, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_XLATE, {20'h0, 12'($urandom)}, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_MAP,   32'h003F_F000, 32'h8000_0000, 12'h800); // last entry of table
    send_cmd(tlpt_pkg::CMD_XLATE, 32'h003F_FABC, 32'h0, 12'h0);
  endtask

  task automatic test_random_traffic(int count);
    logic [1:0] cmd;
    for (int n = 0; n < count; n++) begin
      cmd = pick_cmd();
      send_cmd(cmd, pick_va(cmd), $urandom, 12'($urandom_range(0, 4095)));
    end
  endtask

  // fills whatever is left of the pool, then maps into one more directory
  task automatic test_pool_exhaustion();
    logic [31:0] va;
    while (slots_used < TABLE_SLOTS)
      send_cmd(tlpt_pkg::CMD_MAP, {free_dir(), 22'($urandom)}, $urandom, 12'($urandom));
    va = {free_dir(), 22'($urandom)};
    send_cmd(tlpt_pkg::CMD_MAP, va, $urandom, 12'($urandom));
    send_cmd(tlpt_pkg::CMD_XLATE, va, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_UNMAP, va, 32'h0, 12'h0);
    send_cmd(tlpt_pkg::CMD_MAP, va, 32'hFFFF_FFFF, 12'hFFF);
  endtask

  // receiver holds off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    logic [1:0] cmd;
    hold_output = 1'b1;
    tx_idle_en  = 1'b0;
    for (int n = 0; n < 40; n++) begin
      cmd = pick_cmd();
      send_cmd(cmd, pick_va(cmd), $urandom, 12'($urandom));
    end
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    test_random_traffic(30);
    drain_results();
    test_random_traffic(30);
  endtask

  // result side: random stalls, an occasional long hold, and the compare
  initial begin
    int           stall;
    walk_result_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 4) : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result word %h/%b with nothing outstanding",
                                  m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.phys)
          report_mismatch($sformatf("phys_result %h, expected %h", m_axis_tdata, want.phys));
        if (m_axis_tuser[0] !== want.not_mapped)
          report_mismatch($sformatf("not_mapped %b, expected %b",
                                    m_axis_tuser[0], want.not_mapped));
        if (m_axis_tuser[1] !== want.was_mapped)
          report_mismatch($sformatf("was_mapped %b, expected %b",
                                    m_axis_tuser[1], want.was_mapped));
        if (m_axis_tuser[2] !== want.status)
          report_mismatch($sformatf("status %b, expected %b", m_axis_tuser[2], want.status));
      end
    end
  end

  initial begin
    hot_dirs[0] = 10'h000;
    hot_dirs[1] = 10'h3FF;
    for (int k = 2; k < HOT_DIRS; k++) hot_dirs[k] = 10'($urandom);
    for (int k = 0; k < HOT_TBLS; k++) hot_tbls[k] = 10'($urandom);
    hot_tbls[0] = 10'h000;
    hot_tbls[1] = 10'h3FF;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walks();
    test_random_traffic(500);
    test_pool_exhaustion();
    test_output_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(200);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_drain_pause();
    test_random_traffic(640);

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("covered %0d maps (%0d overwrites, %0d with pool full), %0d unmaps, %0d translates",
             n_map, n_overwrite, n_pool_full, n_unmap, n_xlate);
    $display("%0d translate hits, %0d unused codes, %0d words, %0d of %0d slots used",
             n_hit, n_unused, words_sent, slots_used, TABLE_SLOTS);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // covers the clearing sweep after reset plus a slow run several times over
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tlpt_pkg.sv
rtl/tlpt_ram.sv
rtl/tlpt_ctrl.sv
rtl/tlpt_datapath.sv
rtl/two_level_page_table_engine_core.sv
bench/tb_top.sv
